@@ src/bcc_pkg.sv @@
package bcc_pkg;

    localparam int CountWidthDef = 16;
    localparam int CfgWidth      = 16;
    localparam int StateWidth    = 4;
    localparam int CfgIndexWidth = 2;

    localparam logic [CfgWidth-1:0] DebounceTicksRst    = 16'd65;
    localparam logic [CfgWidth-1:0] SingleClickTicksRst = 16'd100;
    localparam logic [CfgWidth-1:0] LongClickTicksRst   = 16'd300;

    localparam logic [CfgIndexWidth-1:0] RegDebounce    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] RegSingleClick = 2'd1;
    localparam logic [CfgIndexWidth-1:0] RegLongClick   = 2'd2;

    localparam logic [StateWidth-1:0] ST_IDLE         = 4'd0;
    localparam logic [StateWidth-1:0] ST_DEBOUNCE     = 4'd1;
    localparam logic [StateWidth-1:0] ST_PRESSED      = 4'd2;
    localparam logic [StateWidth-1:0] ST_CLICK_UP     = 4'd3;
    localparam logic [StateWidth-1:0] ST_CLICK_IDLE   = 4'd4;
    localparam logic [StateWidth-1:0] ST_SINGLE       = 4'd5;
    localparam logic [StateWidth-1:0] ST_DBL_DEBOUNCE = 4'd6;
    localparam logic [StateWidth-1:0] ST_DOUBLE       = 4'd7;
    localparam logic [StateWidth-1:0] ST_LONG         = 4'd8;
    localparam logic [StateWidth-1:0] ST_OTHER_UP     = 4'd9;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ticks;
        logic [CfgWidth-1:0] single_click_ticks;
        logic [CfgWidth-1:0] long_click_ticks;
    } bcc_cfg_t;

    typedef struct packed {
        logic [StateWidth-1:0] button_state;
        logic                  released;
        logic                  long_click;
        logic                  double_click;
        logic                  single_click;
        logic                  click;
    } bcc_result_t;

endpackage

@@ src/button_click_classifier_unit.sv @@
// output: a request accepted at a clock edge shows its result on m_tvalid in the following cycle
// throughput: one request per cycle; s_tready stays high while the result register is
//   empty or being taken in the same cycle
// reset: synchronous active-low aresetn returns the state to idle, clears the tick counter,
//   empties the result register and loads the timing registers with 65, 100 and 300
module button_click_classifier_unit
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDef
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,    // [0] pressed, [7:1] zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,    // [0] click, [1] single_click,
                                                 // [2] double_click, [3] long_click,
                                                 // [4] released, [8:5] button_state,
                                                 // [15:9] zero
    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]      cfg_wdata
);

    bcc_cfg_t    cfg_reg;
    bcc_result_t res;
    bcc_result_t out_reg;
    logic        out_valid_reg;
    logic        step;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    bcc_fsm #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pressed (s_tdata[0]),
        .cfg     (cfg_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks     <= DebounceTicksRst;
            cfg_reg.single_click_ticks <= SingleClickTicksRst;
            cfg_reg.long_click_ticks   <= LongClickTicksRst;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                RegDebounce:    cfg_reg.debounce_ticks     <= cfg_wdata;
                RegSingleClick: cfg_reg.single_click_ticks <= cfg_wdata;
                RegLongClick:   cfg_reg.long_click_ticks   <= cfg_wdata;
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule

@@ src/bcc_fsm.sv @@
module bcc_fsm
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        pressed,
    input  bcc_cfg_t    cfg,
    output bcc_result_t result
);

    localparam int CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

    logic [StateWidth-1:0]  state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [StateWidth-1:0]  state_cur;
    logic [StateWidth-1:0]  state_eval;
    logic [COUNT_WIDTH-1:0] elapsed;
    logic [CmpWidth-1:0]    elapsed_x;
    logic                   deb_done, single_done, long_done;
    logic                   active, changed;

    assign state_cur = (state_reg > ST_OTHER_UP) ? ST_IDLE : state_reg;
    assign active    = pressed || (state_cur != ST_IDLE);
    assign elapsed   = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
    assign elapsed_x = CmpWidth'(elapsed);

    assign deb_done    = elapsed_x >= CmpWidth'(cfg.debounce_ticks);
    assign single_done = elapsed_x >= CmpWidth'(cfg.single_click_ticks);
    assign long_done   = elapsed_x >= CmpWidth'(cfg.long_click_ticks);

    always_comb begin
        case (state_cur)
            ST_IDLE:         state_eval = pressed ? ST_DEBOUNCE : ST_IDLE;
            ST_DEBOUNCE:     state_eval = !pressed ? ST_IDLE :
                                          (deb_done ? ST_PRESSED : ST_DEBOUNCE);
            ST_PRESSED:      state_eval = !pressed ? ST_CLICK_UP :
                                          (long_done ? ST_LONG : ST_PRESSED);
            ST_CLICK_UP:     state_eval = ST_CLICK_IDLE;
            ST_CLICK_IDLE:   state_eval = pressed ? ST_DBL_DEBOUNCE :
                                          (single_done ? ST_SINGLE : ST_CLICK_IDLE);
            ST_SINGLE:       state_eval = ST_IDLE;
            ST_DBL_DEBOUNCE: state_eval = !pressed ? ST_CLICK_IDLE :
                                          (deb_done ? ST_DOUBLE : ST_DBL_DEBOUNCE);
            ST_DOUBLE:       state_eval = pressed ? ST_DOUBLE : ST_OTHER_UP;
            ST_LONG:         state_eval = pressed ? ST_LONG : ST_OTHER_UP;
            ST_OTHER_UP:     state_eval = ST_IDLE;
            default:         state_eval = pressed ? ST_DEBOUNCE : ST_IDLE;
        endcase
    end

    always_comb begin
        changed    = 1'b0;
        state_next = state_cur;
        cnt_next   = cnt_reg;
        if (active) begin
            state_next = state_eval;
            if (state_eval != state_cur) begin
                changed  = 1'b1;
                cnt_next = '0;
            end else begin
                cnt_next = elapsed;
            end
        end
    end

    assign result.button_state = state_next;
    assign result.click        = changed && (state_next == ST_PRESSED ||
                                             state_next == ST_DOUBLE);
    assign result.single_click = changed && (state_next == ST_SINGLE);
    assign result.double_click = changed && (state_next == ST_DOUBLE);
    assign result.long_click   = changed && (state_next == ST_LONG);
    assign result.released     = changed && (state_next == ST_CLICK_UP ||
                                             state_next == ST_OTHER_UP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else if (step) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
